@@ rtl/segsum_pkg.sv @@
// ----------------------------------------------------------------------------
// segsum_pkg
// Shared types and constants of the segment tree range sum block.
// ----------------------------------------------------------------------------
package segsum_pkg;

  localparam int unsigned DEF_LEAVES     = 1024;
  localparam int unsigned DEF_VALUE_BITS = 32;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_FILL  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_SUM   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_NOT_READY = 2'd2
  } status_e;

  typedef struct packed {
    logic busy;
    logic last;
  } fill_ctrl_t;

endpackage

@@ rtl/segsum_node_ram.sv @@
// ----------------------------------------------------------------------------
// segsum_node_ram
// Node sum memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module segsum_node_ram #(
  parameter int unsigned AW = 11,
  parameter int unsigned VB = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [VB-1:0] wdata_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [VB-1:0] rdata0_o,
  output logic [VB-1:0] rdata1_o
);

  logic [VB-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

@@ rtl/segsum_fill_gen.sv @@
// ----------------------------------------------------------------------------
// segsum_fill_gen
// Fill sweep: writes every node from the last leaf down to the root, one
// node per cycle, with sums built from running full and partial registers.
// ----------------------------------------------------------------------------
module segsum_fill_gen #(
  parameter int unsigned LEAVES     = segsum_pkg::DEF_LEAVES,
  parameter int unsigned VALUE_BITS = segsum_pkg::DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [VALUE_BITS-1:0]        value_i,
  input  logic [$clog2(LEAVES):0]      count_i,
  output logic                         wr_en_o,
  output logic [$clog2(LEAVES):0]      wr_addr_o,
  output logic [VALUE_BITS-1:0]        wr_data_o,
  output segsum_pkg::fill_ctrl_t       ctrl_o
);

  import segsum_pkg::*;

  localparam int unsigned LW = $clog2(LEAVES);
  localparam int unsigned AW = LW + 1;
  localparam int unsigned CW = LW + 1;

  logic                  active_q;
  logic [AW-1:0]         pos_q;
  logic [CW-1:0]         size_q;
  logic [CW-1:0]         start_q;
  logic [CW-1:0]         cnt_q;
  logic [CW-1:0]         cnt_sh_q;
  logic [VALUE_BITS-1:0] full_q;
  logic [VALUE_BITS-1:0] part_q;

  logic [CW-1:0] node_end;
  logic          level_first;
  logic          last;

  assign node_end    = start_q + size_q;
  assign level_first = (pos_q & (pos_q - AW'(1))) == '0;
  assign last        = active_q && (pos_q == AW'(1));

  always_comb begin
    if (node_end <= cnt_q) begin
      wr_data_o = full_q;
    end else if (start_q < cnt_q) begin
      wr_data_o = part_q;
    end else begin
      wr_data_o = '0;
    end
  end

  assign wr_en_o     = active_q;
  assign wr_addr_o   = pos_q;
  assign ctrl_o.busy = active_q;
  assign ctrl_o.last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (start_i) begin
      active_q <= 1'b1;
    end else if (last) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pos_q    <= '1;
      size_q   <= CW'(1);
      start_q  <= CW'(LEAVES - 1);
      cnt_q    <= count_i;
      cnt_sh_q <= count_i;
      full_q   <= value_i;
      part_q   <= '0;
    end else if (active_q && !last) begin
      pos_q <= pos_q - AW'(1);
      if (level_first) begin
        size_q   <= size_q << 1;
        start_q  <= CW'(LEAVES) - (size_q << 1);
        full_q   <= full_q << 1;
        part_q   <= part_q + (cnt_sh_q[0] ? full_q : '0);
        cnt_sh_q <= cnt_sh_q >> 1;
      end else begin
        start_q <= start_q - size_q;
      end
    end
  end

endmodule

@@ rtl/segment_tree_range_sum.sv @@
// ----------------------------------------------------------------------------
// segment_tree_range_sum
// Segment tree of wrapping sums with fill, point write, point read and
// inclusive range sum requests.
// ----------------------------------------------------------------------------
// The tree lives in one node memory with one write and two read ports, with
// registered read data. One request is in work at a time; fill writes one
// node per cycle, point write writes the leaf and then one ancestor per
// cycle, point read reads the leaf, range sum walks one tree level per cycle
// with two nodes per level, and flagged requests go straight to the output.
// A new request is taken as soon as the result sits in the output register.
module segment_tree_range_sum #(
  parameter int unsigned LEAVES     = segsum_pkg::DEF_LEAVES,
  parameter int unsigned VALUE_BITS = segsum_pkg::DEF_VALUE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [segsum_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [segsum_pkg::MODE_W-1:0]   mode_i,
  input  logic        [segsum_pkg::INDEX_W-1:0]  index_low_i,
  input  logic        [segsum_pkg::INDEX_W-1:0]  index_high_i,
  input  logic signed [segsum_pkg::DATA_W-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [segsum_pkg::DATA_W-1:0]   result_o,
  output logic        [segsum_pkg::STATUS_W-1:0] status_o
);

  import segsum_pkg::*;

  localparam int unsigned LW = $clog2(LEAVES);
  localparam int unsigned AW = LW + 1;
  localparam int unsigned RW = LW + 2;
  localparam int unsigned CW = LW + 1;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_FILL      = 8'b0000_0010,
    ST_WRITE     = 8'b0000_0100,
    ST_WR_UP     = 8'b0000_1000,
    ST_READ      = 8'b0001_0000,
    ST_READ_WAIT = 8'b0010_0000,
    ST_SUM       = 8'b0100_0000,
    ST_OUT       = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d, acc_state;
  logic [COUNT_W-1:0]    leaf_count_q;
  logic                  tree_ready_q;
  mode_e                 mode_q, mode_in;
  logic [INDEX_W-1:0]    lo_q;
  status_e               status_q, acc_status;
  logic [VALUE_BITS-1:0] acc_q;
  logic [AW-1:0]         pos_q;
  logic [AW-1:0]         l_q;
  logic [RW-1:0]         r_q;
  logic                  fl_q, fr_q, pend_q;
  logic                  out_valid_q;
  logic [DATA_W-1:0]     result_q;
  status_e               out_status_q;

  logic [CW-1:0]         cnt;
  logic signed [63:0]    value_sx;
  logic [VALUE_BITS-1:0] value_in;
  logic                  accept, lo_bad, hi_bad, reversed, out_load;
  logic [AW-1:0]         leaf_addr, par;
  logic [VALUE_BITS-1:0] up_sum, add0, add1;
  logic                  l_lt_r, sum_done;
  logic [RW-1:0]         l_inc, r_dec;

  logic                  mem_we, fill_we;
  logic [AW-1:0]         mem_waddr, fill_waddr, rd0_addr, rd1_addr;
  logic [VALUE_BITS-1:0] mem_wdata, fill_wdata, rd0, rd1;
  fill_ctrl_t            fill_ctrl;

  always_comb begin
    if (32'(leaf_count_q) > 32'(LEAVES)) begin
      cnt = CW'(LEAVES);
    end else begin
      cnt = CW'(leaf_count_q);
    end
  end

  assign value_sx = 64'(value_i);
  assign value_in = VALUE_BITS'(value_sx);
  assign mode_in  = mode_e'(mode_i);
  assign accept   = in_valid_i && in_ready_o;
  assign lo_bad   = 32'(index_low_i) >= 32'(cnt);
  assign hi_bad   = 32'(index_high_i) >= 32'(cnt);
  assign reversed = index_low_i > index_high_i;

  always_comb begin
    acc_state  = ST_OUT;
    acc_status = STATUS_OK;
    if (mode_in == MODE_FILL) begin
      acc_state = ST_FILL;
    end else if (!tree_ready_q) begin
      acc_status = STATUS_NOT_READY;
    end else begin
      case (mode_in)
        MODE_WRITE: begin
          if (lo_bad) acc_status = STATUS_BAD_INDEX;
          else        acc_state  = ST_WRITE;
        end
        MODE_READ: begin
          if (lo_bad) acc_status = STATUS_BAD_INDEX;
          else        acc_state  = ST_READ;
        end
        MODE_SUM: begin
          if (reversed || hi_bad) acc_status = STATUS_BAD_INDEX;
          else                    acc_state  = ST_SUM;
        end
        default: acc_state = ST_OUT;
      endcase
    end
  end

  assign leaf_addr = AW'(LEAVES) | AW'(lo_q);
  assign par       = pos_q >> 1;
  assign up_sum    = acc_q + rd0;
  assign l_lt_r    = RW'(l_q) < r_q;
  assign sum_done  = !l_lt_r && !pend_q;
  assign l_inc     = RW'(l_q) + RW'(l_q[0]);
  assign r_dec     = r_q - RW'(r_q[0]);
  assign add0      = fl_q ? rd0 : '0;
  assign add1      = fr_q ? rd1 : '0;
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (accept) state_d = acc_state;
      ST_FILL:      if (fill_ctrl.last) state_d = ST_OUT;
      ST_WRITE:     state_d = ST_WR_UP;
      ST_WR_UP:     if (par == AW'(1)) state_d = ST_OUT;
      ST_READ:      state_d = ST_READ_WAIT;
      ST_READ_WAIT: state_d = ST_OUT;
      ST_SUM:       if (sum_done) state_d = ST_OUT;
      ST_OUT:       if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = leaf_addr;
    mem_wdata = acc_q;
    rd0_addr  = leaf_addr;
    case (state_q)
      ST_FILL: begin
        mem_we    = fill_we;
        mem_waddr = fill_waddr;
        mem_wdata = fill_wdata;
      end
      ST_WRITE: begin
        mem_we   = 1'b1;
        rd0_addr = leaf_addr ^ AW'(1);
      end
      ST_WR_UP: begin
        mem_we    = 1'b1;
        mem_waddr = par;
        mem_wdata = up_sum;
        rd0_addr  = par ^ AW'(1);
      end
      ST_SUM:  rd0_addr = l_q;
      default: rd0_addr = leaf_addr;
    endcase
  end

  assign rd1_addr = AW'(r_q - RW'(1));

  segsum_fill_gen #(
    .LEAVES     (LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_fill_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && (mode_in == MODE_FILL)),
    .value_i   (value_in),
    .count_i   (cnt),
    .wr_en_o   (fill_we),
    .wr_addr_o (fill_waddr),
    .wr_data_o (fill_wdata),
    .ctrl_o    (fill_ctrl)
  );

  segsum_node_ram #(
    .AW (AW),
    .VB (VALUE_BITS)
  ) u_node_ram (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr0_i (rd0_addr),
    .raddr1_i (rd1_addr),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tree_ready_q <= 1'b0;
      leaf_count_q <= COUNT_RESET;
      out_valid_q  <= 1'b0;
      pend_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && (mode_in == MODE_FILL)) begin
        tree_ready_q <= 1'b1;
      end
      if (cfg_we_i) begin
        leaf_count_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      pend_q <= (state_q == ST_SUM) && l_lt_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_in;
      lo_q     <= index_low_i;
      status_q <= acc_status;
      acc_q    <= (mode_in == MODE_WRITE) ? value_in : '0;
      l_q      <= AW'(LEAVES) | AW'(index_low_i);
      r_q      <= RW'(LEAVES) + RW'(index_high_i) + RW'(1);
    end
    case (state_q)
      ST_WRITE: pos_q <= leaf_addr;
      ST_WR_UP: begin
        pos_q <= par;
        acc_q <= up_sum;
      end
      ST_READ_WAIT: acc_q <= rd0;
      ST_SUM: begin
        if (l_lt_r) begin
          fl_q <= l_q[0];
          fr_q <= r_q[0];
          l_q  <= AW'(l_inc >> 1);
          r_q  <= r_dec >> 1;
        end
        if (pend_q) begin
          acc_q <= acc_q + add0 + add1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      result_q     <= ((status_q == STATUS_OK) &&
                       ((mode_q == MODE_READ) || (mode_q == MODE_SUM))) ?
                      DATA_W'(acc_q) : '0;
      out_status_q <= status_q;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign result_o    = $signed(result_q);
  assign status_o    = out_status_q;

  // idle means no fill sweep left running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !fill_ctrl.busy)
    else $error("fill sweep active while idle");

  // an accepted request blocks the next one from being taken right behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken twice in a row");

  // flagged results carry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_OK)) |-> (result_o == '0))
    else $error("nonzero result on flagged request");

  // tree walks only after a fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WR_UP) || (state_q == ST_SUM) || (state_q == ST_READ)) |-> tree_ready_q)
    else $error("tree walked before fill");

endmodule

@@ dv/tb_segment_tree_range_sum.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_tree_range_sum
// Self-checking bench for the segment tree range sum block. Requests are sent
// over a valid/ready channel with random gaps. A mirror of the leaf values
// predicts each response (fill, point write, point read, range sum, and the
// flagged cases). Responses come back through a randomly stalled receiver
// and are compared field by field in order. The leaf count register is
// rewritten between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_segment_tree_range_sum;
  import segsum_pkg::*;

  localparam int unsigned NUM_LEAVES  = DEF_LEAVES;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT  = 100;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    status_e           status;
  } response_t;

  class leaf_sum_tracker;
    logic [DATA_W-1:0]  leaf_val [NUM_LEAVES];
    logic [COUNT_W-1:0] leaf_count;
    bit                 filled;
    response_t          pending_responses [$];
    int unsigned        mode_count [4];
    int unsigned        flagged;
    int unsigned        checked;
    int unsigned        errors;
    int unsigned        count_settings;

    function new();
      foreach (leaf_val[i]) leaf_val[i] = '0;
      leaf_count     = COUNT_RESET;
      filled         = 1'b0;
      flagged        = 0;
      checked        = 0;
      errors         = 0;
      count_settings = 1;
      foreach (mode_count[i]) mode_count[i] = 0;
    endfunction

    function void set_leaf_count(logic [COUNT_W-1:0] count);
      leaf_count = count;
      count_settings++;
    endfunction

    function int unsigned used_leaves();
      return (leaf_count > NUM_LEAVES) ? NUM_LEAVES : int'(leaf_count);
    endfunction

    function int unsigned pending();
      return pending_responses.size();
    endfunction

    function void note_request(mode_e m, logic [INDEX_W-1:0] lo, logic [INDEX_W-1:0] hi,
                               logic [DATA_W-1:0] v);
      response_t   exp;
      int unsigned cnt;
      exp.result = '0;
      exp.status = STATUS_OK;
      cnt = used_leaves();
      mode_count[m]++;
      if (m == MODE_FILL) begin
        for (int i = 0; i < NUM_LEAVES; i++) leaf_val[i] = (i < cnt) ? v : '0;
        filled = 1'b1;
      end else if (!filled) begin
        exp.status = STATUS_NOT_READY;
      end else if (m == MODE_WRITE) begin
        if (lo >= cnt) exp.status = STATUS_BAD_INDEX;
        else leaf_val[lo] = v;
      end else if (m == MODE_READ) begin
        if (lo >= cnt) exp.status = STATUS_BAD_INDEX;
        else exp.result = leaf_val[lo];
      end else begin
        if (lo > hi || hi >= cnt) exp.status = STATUS_BAD_INDEX;
        else for (int i = int'(lo); i <= hi; i++) exp.result = exp.result + leaf_val[i];
      end
      if (exp.status != STATUS_OK) flagged++;
      pending_responses = {pending_responses, exp};
    endfunction

    function void check_result(logic [DATA_W-1:0] got_result, logic [STATUS_W-1:0] got_status);
      response_t exp;
      if (pending_responses.size() == 0) begin
        $error("unexpected response: result %h, status %0d", got_result, got_status);
        errors++;
        return;
      end
      exp = pending_responses.pop_front();
      checked++;
      if (got_result !== exp.result) begin
        $error("result mismatch: expected %h, actual %h", exp.result, got_result);
        errors++;
      end
      if (got_status !== exp.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp.status, got_status);
        errors++;
      end
    endfunction

    function void check_leftover();
      if (pending_responses.size() != 0) begin
        $error("%0d responses never arrived", pending_responses.size());
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       cfg_we_i     = 1'b0;
  logic        [COUNT_W-1:0]  cfg_wdata_i  = '0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic        [MODE_W-1:0]   mode_i       = '0;
  logic        [INDEX_W-1:0]  index_low_i  = '0;
  logic        [INDEX_W-1:0]  index_high_i = '0;
  logic signed [DATA_W-1:0]   value_i      = '0;
  logic                       out_valid_o;
  logic                       out_ready_i  = 1'b0;
  logic signed [DATA_W-1:0]   result_o;
  logic        [STATUS_W-1:0] status_o;

  leaf_sum_tracker tracker = new();
  bit              no_idle = 1'b0;
  int unsigned     stall_left = 0;
  int unsigned     idle_cycles = 0;

  segment_tree_range_sum dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .index_low_i  (index_low_i),
    .index_high_i (index_high_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result_o),
    .status_o     (status_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned next_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 20) begin
      stall_left  <= next_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // response transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_result(result_o, status_o);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(input mode_e m, input logic [INDEX_W-1:0] lo,
                              input logic [INDEX_W-1:0] hi, input logic [DATA_W-1:0] v);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    index_low_i  <= lo;
    index_high_i <= hi;
    value_i      <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_request(m, lo, hi, v);
  endtask

  task automatic wait_for_responses();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_leaf_count(input logic [COUNT_W-1:0] count);
    wait_for_responses();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_leaf_count(count);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return '0;
      4, 5:    return DATA_W'(int'($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index(int unsigned cnt);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cnt == 0 || r >= 92) return INDEX_W'($urandom_range(0, NUM_LEAVES - 1));
    if (r < 4) return '0;
    if (r < 8) return INDEX_W'(cnt - 1);
    return INDEX_W'($urandom_range(0, cnt - 1));
  endfunction

  task automatic random_requests(input int unsigned n);
    int unsigned        r;
    int unsigned        cnt;
    mode_e              m;
    logic [INDEX_W-1:0] lo;
    logic [INDEX_W-1:0] hi;
    logic [INDEX_W-1:0] tmp;
    for (int k = 0; k < n; k++) begin
      cnt = tracker.used_leaves();
      r = $urandom_range(0, 99);
      if (r < 2) m = MODE_FILL;
      else if (r < 37) m = MODE_WRITE;
      else if (r < 62) m = MODE_READ;
      else m = MODE_SUM;
      lo = pick_index(cnt);
      hi = pick_index(cnt);
      if (m == MODE_SUM && lo > hi && $urandom_range(0, 99) < 88) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      send_request(m, lo, hi, pick_value());
    end
  endtask

  task automatic directed_requests();
    // requests before the first fill
    send_request(MODE_WRITE, 10'd5, 10'd0, 32'h1234_5678);
    send_request(MODE_READ, 10'd0, 10'd0, '0);
    send_request(MODE_SUM, 10'd0, 10'd1023, '0);
    send_request(MODE_FILL, 10'd0, 10'd0, 32'h7fff_ffff);
    send_request(MODE_SUM, 10'd0, 10'd1023, '0);
    send_request(MODE_WRITE, 10'd1023, 10'd0, 32'h8000_0000);
    send_request(MODE_WRITE, 10'd0, 10'd1023, 32'hffff_ffff);
    send_request(MODE_READ, 10'd1023, 10'd0, '0);
    send_request(MODE_READ, 10'd0, 10'd0, '0);
    send_request(MODE_SUM, 10'd0, 10'd0, '0);
    send_request(MODE_SUM, 10'd1023, 10'd1023, '0);
    // reversed range
    send_request(MODE_SUM, 10'd10, 10'd9, '0);
    send_request(MODE_SUM, 10'd1, 10'd1023, '0);
    // count above the leaf total behaves as the full tree
    write_leaf_count(11'd2047);
    send_request(MODE_READ, 10'd1023, 10'd0, '0);
    send_request(MODE_SUM, 10'd3, 10'd1000, '0);
    // zero count: every index is bad and a fill clears all leaves
    write_leaf_count(11'd0);
    send_request(MODE_READ, 10'd0, 10'd0, '0);
    send_request(MODE_WRITE, 10'd0, 10'd0, 32'h0bad_0bad);
    send_request(MODE_FILL, 10'd0, 10'd0, 32'h1234_5678);
    send_request(MODE_SUM, 10'd0, 10'd0, '0);
    write_leaf_count(11'd1);
    send_request(MODE_READ, 10'd0, 10'd0, '0);
    send_request(MODE_WRITE, 10'd0, 10'd0, 32'h55aa_55aa);
    send_request(MODE_READ, 10'd1, 10'd0, '0);
    send_request(MODE_SUM, 10'd0, 10'd0, '0);
    send_request(MODE_FILL, 10'd0, 10'd0, 32'ha5a5_a5a5);
    // leaves outside the old count stay zero after widening
    write_leaf_count(11'd1024);
    send_request(MODE_SUM, 10'd0, 10'd1023, '0);
    send_request(MODE_READ, 10'd1, 10'd0, '0);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_requests();

    random_requests(45);
    // sender holds off until every response is back
    wait_for_responses();
    random_requests(45);

    write_leaf_count(11'd2047);
    no_idle = 1'b1;
    random_requests(80);
    no_idle = 1'b0;

    write_leaf_count(11'd64);
    send_request(MODE_FILL, 10'd0, 10'd0, pick_value());
    random_requests(90);

    write_leaf_count(11'd1);
    random_requests(60);

    write_leaf_count(COUNT_W'($urandom_range(2, NUM_LEAVES - 1)));
    random_requests(90);

    write_leaf_count(11'd1000);
    random_requests(90);

    wait_for_responses();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    tracker.check_leftover();

    $display("summary: %0d requests (%0d fill, %0d write, %0d read, %0d sum), %0d flagged",
             tracker.mode_count[MODE_FILL] + tracker.mode_count[MODE_WRITE] +
             tracker.mode_count[MODE_READ] + tracker.mode_count[MODE_SUM],
             tracker.mode_count[MODE_FILL], tracker.mode_count[MODE_WRITE],
             tracker.mode_count[MODE_READ], tracker.mode_count[MODE_SUM], tracker.flagged);
    $display("summary: %0d responses checked across %0d leaf count settings",
             tracker.checked, tracker.count_settings);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
